// File: hw/rtl/pcbd_pkg.sv
// Shared types and constants of the panel command byte decoder.
`default_nettype none

package pcbd_pkg;

	// Panel geometry.
	localparam int UNIT_COUNT        = 4;
	localparam int DISPLAY_ROW_BYTES = 41;
	localparam int NOTE_SLOTS        = 64;

	// Result queue between the decode stage and the event port.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Command and reply codes of the byte stream.
	localparam logic [7:0] CMD_GAUGE       = 8'h01;
	localparam logic [7:0] CMD_DISPLAY     = 8'h02;
	localparam logic [7:0] CMD_BRIGHT      = 8'h03;
	localparam logic [7:0] CMD_AUDIO       = 8'h04;
	localparam logic [7:0] CMD_RESET       = 8'hFF;
	localparam logic [7:0] REPLY_RESET_ACK = 8'hFE;
	localparam logic [7:0] REPLY_AUDIO_BAD = 8'hA2;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_GAUGE     = 3'd1,
		EV_BRIGHT    = 3'd2,
		EV_DISP      = 3'd3,
		EV_NOTE      = 3'd4,
		EV_AUDIO_LEN = 3'd5,
		EV_REPLY     = 3'd6
	} event_kind_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_GAUGE_INDEX,
		PH_GAUGE_TARGET,
		PH_BRIGHT_VALUE,
		PH_DISP_INDEX,
		PH_DISP_DATA,
		PH_AUDIO_COUNT,
		PH_AUDIO_DATA,
		PH_AUDIO_SKIP
	} parse_phase_t;

	typedef struct packed {
		event_kind_t kind;
		logic [1:0]  unit;
		logic [5:0]  slot;
		logic [15:0] data;
		logic        last;
	} result_t;

endpackage : pcbd_pkg

`default_nettype wire

// File: hw/rtl/panel_command_byte_decoder_core.sv
// Panel command byte decoder: byte parser, decode stage and result queue.
//
// The receive channel (rx_valid, rx_stall, rx_byte) takes one byte of the
// command stream per request. The event channel (ev_valid, ev_stall and the
// result fields) hands out the write events and replies that the bytes cause,
// one per request, in stream order. A byte causes no event, one event, or
// two events (the final note word of an audio command is followed by the
// audio length event); last_of_run marks the final event of each byte.
// A taken byte is registered in the decode stage; once that stage moves
// on, its events are written into the result queue and offered from it.
// Throughput: one byte per cycle, sustained while the event channel is not
// stalled. The limit is the single parse state update per cycle; the
// four-entry result queue absorbs the odd byte that yields two events while
// the event side drains one per cycle.
// When the receiver stalls the event channel, the queue fills; once more
// than two entries are occupied the decode stage holds its byte and
// rx_stall rises, so nothing is lost. A stalled event does not change.
// Reset (arst_n low) empties the queue and the decode stage and returns the
// parser to idle, waiting for a command byte.
`default_nettype none

module panel_command_byte_decoder_core #(
	parameter int UNIT_COUNT        = pcbd_pkg::UNIT_COUNT,
	parameter int DISPLAY_ROW_BYTES = pcbd_pkg::DISPLAY_ROW_BYTES,
	parameter int NOTE_SLOTS        = pcbd_pkg::NOTE_SLOTS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rx_valid,
	output logic             rx_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             ev_valid,
	input  wire logic        ev_stall,
	output logic [2:0]       event_kind,
	output logic [1:0]       unit_index,
	output logic [5:0]       slot_index,
	output logic [15:0]      data_value,
	output logic             last_of_run
);

	localparam int AW = pcbd_pkg::QUEUE_AW;

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       rx_acc;
	logic       adv;

	// Parser state.
	pcbd_pkg::parse_phase_t phase_q, phase_d;
	logic [1:0] unit_q, unit_d;
	logic       unit_bad_q, unit_bad_d;
	logic [6:0] pos_q, pos_d;
	logic [8:0] remain_q, remain_d;
	logic [5:0] note_total_q, note_total_d;
	logic [7:0] hi_latch_q, hi_latch_d;

	// Decode outputs.
	logic [1:0]         n_res;
	pcbd_pkg::result_t  res0, res1;
	logic [6:0]         pos_inc;

	// Result queue.
	pcbd_pkg::result_t queue_q [pcbd_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   count_q;
	logic          pop;
	logic [AW:0]   push_n;

	// The decode stage moves on only while the queue can take two results,
	// judged from the registered fill so that the stall does not depend on
	// the event side within the cycle.
	assign adv      = valid_s1 && (count_q <= (AW+1)'(pcbd_pkg::QUEUE_DEPTH - 2));
	assign rx_stall = valid_s1 && !adv;
	assign rx_acc   = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_acc) begin
			byte_s1 <= rx_byte;
		end
	end

	assign pos_inc = pos_q + 7'd1;

	// Next parser state.
	always_comb begin
		phase_d      = phase_q;
		unit_d       = unit_q;
		unit_bad_d   = unit_bad_q;
		pos_d        = pos_q;
		remain_d     = remain_q;
		note_total_d = note_total_q;
		hi_latch_d   = hi_latch_q;
		case (phase_q)
			pcbd_pkg::PH_IDLE: begin
				case (byte_s1)
					pcbd_pkg::CMD_GAUGE:   phase_d = pcbd_pkg::PH_GAUGE_INDEX;
					pcbd_pkg::CMD_BRIGHT:  phase_d = pcbd_pkg::PH_BRIGHT_VALUE;
					pcbd_pkg::CMD_DISPLAY: phase_d = pcbd_pkg::PH_DISP_INDEX;
					pcbd_pkg::CMD_AUDIO: begin
						phase_d = pcbd_pkg::PH_AUDIO_COUNT;
						pos_d   = '0;
					end
					default: ;
				endcase
			end
			pcbd_pkg::PH_GAUGE_INDEX: begin
				unit_d     = byte_s1[1:0];
				unit_bad_d = byte_s1 >= 8'(UNIT_COUNT);
				phase_d    = pcbd_pkg::PH_GAUGE_TARGET;
			end
			pcbd_pkg::PH_GAUGE_TARGET,
			pcbd_pkg::PH_BRIGHT_VALUE: begin
				phase_d = pcbd_pkg::PH_IDLE;
			end
			pcbd_pkg::PH_DISP_INDEX: begin
				unit_d     = byte_s1[1:0];
				unit_bad_d = byte_s1 >= 8'(UNIT_COUNT);
				pos_d      = '0;
				phase_d    = pcbd_pkg::PH_DISP_DATA;
			end
			pcbd_pkg::PH_DISP_DATA: begin
				pos_d = pos_inc;
				if (pos_inc >= 7'(DISPLAY_ROW_BYTES)) begin
					phase_d = pcbd_pkg::PH_IDLE;
				end
			end
			pcbd_pkg::PH_AUDIO_COUNT: begin
				pos_d    = '0;
				remain_d = '0;
				if (byte_s1 >= 8'(NOTE_SLOTS)) begin
					// Too many notes: skip both bytes of every announced word.
					remain_d = {byte_s1, 1'b0};
					phase_d  = ({byte_s1, 1'b0} != 9'd0) ? pcbd_pkg::PH_AUDIO_SKIP
						: pcbd_pkg::PH_IDLE;
				end else begin
					note_total_d = byte_s1[5:0];
					phase_d      = (byte_s1 == 8'd0) ? pcbd_pkg::PH_IDLE
						: pcbd_pkg::PH_AUDIO_DATA;
				end
			end
			pcbd_pkg::PH_AUDIO_DATA: begin
				pos_d = pos_inc;
				if (!pos_q[0]) begin
					hi_latch_d = byte_s1;
				end else if (pos_inc[6:1] >= note_total_q) begin
					phase_d = pcbd_pkg::PH_IDLE;
				end
			end
			pcbd_pkg::PH_AUDIO_SKIP: begin
				if (remain_q != 9'd0) begin
					remain_d = remain_q - 9'd1;
				end
				if (remain_q <= 9'd1) begin
					phase_d = pcbd_pkg::PH_IDLE;
				end
			end
			default: phase_d = pcbd_pkg::PH_IDLE;
		endcase
	end

	// Results caused by the byte in the decode stage.
	always_comb begin
		n_res = 2'd0;
		res0  = '{kind: pcbd_pkg::EV_NONE, unit: '0, slot: '0, data: '0, last: 1'b1};
		res1  = '{kind: pcbd_pkg::EV_NONE, unit: '0, slot: '0, data: '0, last: 1'b1};
		case (phase_q)
			pcbd_pkg::PH_IDLE: begin
				if (byte_s1 == pcbd_pkg::CMD_RESET) begin
					n_res     = 2'd1;
					res0.kind = pcbd_pkg::EV_REPLY;
					res0.data = {8'h00, pcbd_pkg::REPLY_RESET_ACK};
				end
			end
			pcbd_pkg::PH_GAUGE_TARGET: begin
				if (!unit_bad_q) begin
					n_res     = 2'd1;
					res0.kind = pcbd_pkg::EV_GAUGE;
					res0.unit = unit_q;
					res0.data = {8'h00, byte_s1};
				end
			end
			pcbd_pkg::PH_BRIGHT_VALUE: begin
				n_res     = 2'd1;
				res0.kind = pcbd_pkg::EV_BRIGHT;
				res0.data = {8'h00, byte_s1};
			end
			pcbd_pkg::PH_DISP_DATA: begin
				if (!unit_bad_q) begin
					n_res     = 2'd1;
					res0.kind = pcbd_pkg::EV_DISP;
					res0.unit = unit_q;
					res0.slot = pos_q[5:0];
					res0.data = {8'h00, byte_s1};
				end
			end
			pcbd_pkg::PH_AUDIO_COUNT: begin
				if (byte_s1 >= 8'(NOTE_SLOTS)) begin
					n_res     = 2'd1;
					res0.kind = pcbd_pkg::EV_REPLY;
					res0.data = {8'h00, pcbd_pkg::REPLY_AUDIO_BAD};
				end else if (byte_s1 == 8'd0) begin
					n_res     = 2'd1;
					res0.kind = pcbd_pkg::EV_AUDIO_LEN;
				end
			end
			pcbd_pkg::PH_AUDIO_DATA: begin
				if (pos_q[0]) begin
					n_res     = 2'd1;
					res0.kind = pcbd_pkg::EV_NOTE;
					res0.slot = pos_q[6:1];
					res0.data = {hi_latch_q, byte_s1};
					// The final note word is followed by the audio length.
					if (pos_inc[6:1] >= note_total_q) begin
						n_res     = 2'd2;
						res0.last = 1'b0;
						res1.kind = pcbd_pkg::EV_AUDIO_LEN;
						res1.data = {10'd0, note_total_q};
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= pcbd_pkg::PH_IDLE;
			unit_q       <= '0;
			unit_bad_q   <= 1'b0;
			pos_q        <= '0;
			remain_q     <= '0;
			note_total_q <= '0;
			hi_latch_q   <= '0;
		end else if (adv) begin
			phase_q      <= phase_d;
			unit_q       <= unit_d;
			unit_bad_q   <= unit_bad_d;
			pos_q        <= pos_d;
			remain_q     <= remain_d;
			note_total_q <= note_total_d;
			hi_latch_q   <= hi_latch_d;
		end
	end

	// Result queue.
	assign pop    = ev_valid && !ev_stall;
	assign push_n = adv ? (AW+1)'(n_res) : '0;

	always_ff @(posedge clk) begin
		if (adv && n_res != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (adv && n_res == 2'd2) begin
			queue_q[wr_ptr_q + AW'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[AW-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			count_q <= count_q + push_n - (AW+1)'(pop);
		end
	end

	assign ev_valid    = count_q != '0;
	assign event_kind  = queue_q[rd_ptr_q].kind;
	assign unit_index  = queue_q[rd_ptr_q].unit;
	assign slot_index  = queue_q[rd_ptr_q].slot;
	assign data_value  = queue_q[rd_ptr_q].data;
	assign last_of_run = queue_q[rd_ptr_q].last;

endmodule : panel_command_byte_decoder_core

`default_nettype wire

// File: hw/rtl/pcbd_checker.sv
// Port-level checks of the panel command byte decoder and their binding.
`default_nettype none

module pcbd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rx_valid,
	input wire logic        rx_stall,
	input wire logic [7:0]  rx_byte,
	input wire logic        ev_valid,
	input wire logic        ev_stall,
	input wire logic [2:0]  event_kind,
	input wire logic [1:0]  unit_index,
	input wire logic [5:0]  slot_index,
	input wire logic [15:0] data_value,
	input wire logic        last_of_run
);

	// A stalled event stays offered.
	a_ev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && ev_stall |=> ev_valid)
		else $error("event withdrawn while stalled");

	// Only real event kinds are ever offered.
	a_kind_real: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid |-> (event_kind != pcbd_pkg::EV_NONE && event_kind != 3'd7))
		else $error("event of no kind offered");

	// Only gauge and display events carry a unit number.
	a_unit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && event_kind != pcbd_pkg::EV_GAUGE && event_kind != pcbd_pkg::EV_DISP
		|-> unit_index == 2'd0)
		else $error("unit number on an event that has none");

	// A note word that is not last for its byte is followed at once by the
	// audio length.
	a_len_follows: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && !ev_stall && event_kind == pcbd_pkg::EV_NOTE && !last_of_run
		|=> ev_valid && event_kind == pcbd_pkg::EV_AUDIO_LEN && last_of_run)
		else $error("audio length missing after final note");

endmodule : pcbd_checker

bind panel_command_byte_decoder_core pcbd_checker u_pcbd_checker (.*);

`default_nettype wire
